>>> sv/rmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_pkg: running statistics shared definitions
// Field widths, serial unit constants, sequencer states and the control and
// status bundles that pass between the sequencer and its serial units.
// ----------------------------------------------------------------------------
package rmv_pkg;

  // Field widths of the sample and result beats
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 64;
  localparam int MEAN_W   = SAMPLE_W + FRAC_W;
  localparam int M2_W     = 64;
  localparam int VAR_W    = 63;
  localparam int POS_W    = 32;

  // Working widths: deviation from the mean, its magnitude and the product of two magnitudes
  localparam int DELTA_W  = MEAN_W + 1;
  localparam int MAG_W    = MEAN_W;
  localparam int PROD_W   = 2 * MAG_W;

  // Serial divider operand widths
  localparam int DIVIDEND_W = M2_W;
  localparam int DIVISOR_W  = COUNT_W;
  localparam int DIV_PAD_W  = DIVIDEND_W - MAG_W;

  // Bits retired per cycle in the divider and multiplier
  localparam int SER_DIGIT = 2;
  localparam int SER_CNT_W = 5;

  // Last step index of each serial operation
  localparam logic [SER_CNT_W-1:0] MEAN_DIV_LAST = SER_CNT_W'(MAG_W / SER_DIGIT - 1);
  localparam logic [SER_CNT_W-1:0] VAR_DIV_LAST  = SER_CNT_W'(DIVIDEND_W / SER_DIGIT - 1);
  localparam logic [SER_CNT_W-1:0] MUL_LAST      = SER_CNT_W'(MAG_W / SER_DIGIT - 1);

  // Start request to a serial unit
  typedef struct packed {
    logic                 start;
    logic [SER_CNT_W-1:0] last;
  } ser_ctl_t;

  // Status back from a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } ser_sts_t;

  // Result beat
  typedef struct packed {
    logic        [COUNT_W-1:0]  sample_count;
    logic signed [TOTAL_W-1:0]  running_total;
    logic signed [MEAN_W-1:0]   running_mean;
    logic        [VAR_W-1:0]    sample_variance;
    logic signed [SAMPLE_W-1:0] max_value;
    logic        [POS_W-1:0]    max_position;
    logic signed [SAMPLE_W-1:0] min_value;
    logic        [POS_W-1:0]    min_position;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> sv/rmv_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_in_if: sample channel
// Valid/ready channel that carries one sample and its restart flag per beat.
// ----------------------------------------------------------------------------
interface rmv_in_if import rmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface
`default_nettype wire

>>> sv/rmv_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_out_if: statistics channel
// Valid/ready channel that carries one full set of running statistics a beat.
// ----------------------------------------------------------------------------
interface rmv_out_if import rmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [COUNT_W-1:0]  sample_count;
  logic signed [TOTAL_W-1:0]  running_total;
  logic signed [MEAN_W-1:0]   running_mean;
  logic        [VAR_W-1:0]    sample_variance;
  logic signed [SAMPLE_W-1:0] max_value;
  logic        [POS_W-1:0]    max_position;
  logic signed [SAMPLE_W-1:0] min_value;
  logic        [POS_W-1:0]    min_position;

  modport source (
    output valid, input ready,
    output sample_count, output running_total, output running_mean,
    output sample_variance, output max_value, output max_position,
    output min_value, output min_position
  );
  modport sink (
    input valid, output ready,
    input sample_count, input running_total, input running_mean,
    input sample_variance, input max_value, input max_position,
    input min_value, input min_position
  );
endinterface
`default_nettype wire

>>> sv/rmv_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_div: serial restoring divider
// Unsigned dividend over divisor, SER_DIGIT quotient bits a cycle. The
// dividend is left aligned; once the last step is done the low bits hold the quotient.
// ----------------------------------------------------------------------------
module rmv_div import rmv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ser_ctl_t              ctl,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output ser_sts_t              sts,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [SER_CNT_W-1:0]  cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVIDEND_W-1:0] dq_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] dq_nxt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;

  // Retire SER_DIGIT quotient bits: shift in, trial subtract, restore
  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    shifted = '0;
    trial   = '0;
    for (int i = 0; i < SER_DIGIT; i++) begin
      shifted = {rem_nxt, dq_nxt[DIVIDEND_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_r};
      dq_nxt  = {dq_nxt[DIVIDEND_W-2:0], ~trial[DIVISOR_W+1]};
      rem_nxt = trial[DIVISOR_W+1] ? shifted[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.last;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - SER_CNT_W'(1);
        end
      end
    end
  end

  // Load operands, then advance the partial remainder
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dq_r;

  // A new division never starts on top of a running one
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider started while busy");

endmodule
`default_nettype wire

>>> sv/rmv_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmv_mul: serial shift-add multiplier
// Unsigned magnitude product, SER_DIGIT multiplier bits a cycle, narrow adder.
// ----------------------------------------------------------------------------
module rmv_mul import rmv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ser_ctl_t          ctl,
  input  logic [MAG_W-1:0]  mcand,
  input  logic [MAG_W-1:0]  mplier,
  output ser_sts_t          sts,
  output logic [PROD_W-1:0] product
);

  logic                 busy_r;
  logic                 done_r;
  logic [SER_CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0]     mcand_r;
  logic [PROD_W-1:0]    acc_r;
  logic [PROD_W-1:0]    acc_nxt;
  logic [MAG_W:0]       upper;

  // Add the multiplicand into the upper half on a set bit, then shift right
  always_comb begin
    acc_nxt = acc_r;
    upper   = '0;
    for (int i = 0; i < SER_DIGIT; i++) begin
      upper   = {1'b0, acc_nxt[PROD_W-1:MAG_W]} +
                (acc_nxt[0] ? {1'b0, mcand_r} : {(MAG_W+1){1'b0}});
      acc_nxt = {upper, acc_nxt[MAG_W-1:1]};
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.last;
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - SER_CNT_W'(1);
        end
      end
    end
  end

  // Load operands, then advance the accumulator
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand_r <= mcand;
      acc_r   <= {{MAG_W{1'b0}}, mplier};
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;

  // A new product never starts on top of a running one
  a_mul_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("multiplier started while busy");

endmodule
`default_nettype wire

>>> sv/running_mean_variance_minmax.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_mean_variance_minmax: running count, sum, mean, variance, extremes
// Welford update of mean and m2 with serial divide and multiply units.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one signed sample and a restart flag per beat; restart
//   clears all statistics before the sample is taken as the first one.
//   out_bus carries one beat per sample: count, saturating total, mean and
//   variance with 16 fraction bits, and the extremes with first positions.
//   Each sample runs a serial divide of the deviation by the count, a
//   shift-add multiply for the m2 increment and a divide of m2 by the count
//   minus one (two quotient bits a cycle); the variance divide is skipped
//   when the count is below two. A new sample is taken only after the result
//   of the last one has gone to the output register.
//   in_bus.ready is high only while the sequencer is idle; the finished
//   result sits in an output register, so the next sample is taken while it
//   still waits. If the receiver stalls, the following sample is computed and
//   held until the output register frees.
//   Reset (rst_n low, synchronous) clears the statistics: count, total, mean
//   and m2 to zero, max to the most negative and min to the most positive
//   value, both positions to all ones, and drops any result in flight.
// ----------------------------------------------------------------------------
module running_mean_variance_minmax import rmv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rmv_in_if.sink    in_bus,
  rmv_out_if.source out_bus
);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [TOTAL_W-1:0]  TOTAL_MAX  = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0]  TOTAL_MIN  = {1'b1, {(TOTAL_W-1){1'b0}}};

  // Magnitude of a deviation, which always fits MAG_W bits
  function automatic logic [MAG_W-1:0] mag_of(input logic [DELTA_W-1:0] v);
    logic [DELTA_W-1:0] neg;
    neg = ~v + DELTA_W'(1);
    return v[DELTA_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  // Statistics
  logic        [COUNT_W-1:0]  count_r;
  logic signed [TOTAL_W-1:0]  total_r;
  logic        [MEAN_W-1:0]   mean_r;
  logic        [M2_W-1:0]     m2_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic        [POS_W-1:0]    max_idx_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic        [POS_W-1:0]    min_idx_r;

  // Per-sample working registers
  logic [MEAN_W-1:0]  xf_r;
  logic [DELTA_W-1:0] delta_r;
  logic [VAR_W-1:0]   var_r;

  result_t out_r;
  logic    out_valid_r;

  logic in_rdy;
  logic in_acc;
  logic out_load;

  // Values after an optional restart
  logic        [COUNT_W-1:0]  cnt_base;
  logic signed [TOTAL_W-1:0]  total_base;
  logic        [MEAN_W-1:0]   mean_base;
  logic        [M2_W-1:0]     m2_base;
  logic signed [SAMPLE_W-1:0] max_base;
  logic        [POS_W-1:0]    max_idx_base;
  logic signed [SAMPLE_W-1:0] min_base;
  logic        [POS_W-1:0]    min_idx_base;

  logic        [COUNT_W-1:0]  count_nxt;
  logic        [POS_W-1:0]    pos_nxt;
  logic signed [TOTAL_W-1:0]  sample_ext;
  logic signed [TOTAL_W-1:0]  total_sum;
  logic signed [TOTAL_W-1:0]  total_nxt;
  logic        [MEAN_W-1:0]   xf_nxt;
  logic        [DELTA_W-1:0]  delta_nxt;
  logic                       take_max;
  logic                       take_min;

  logic [MEAN_W-1:0]  mean_upd;
  logic [DELTA_W-1:0] dev_new;
  logic [M2_W-1:0]    m2_inc;
  logic [M2_W:0]      m2_sum;
  logic [M2_W-1:0]    m2_upd;
  logic [VAR_W-1:0]   var_upd;

  ser_ctl_t              div_ctl;
  ser_sts_t              div_sts;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;

  ser_ctl_t          mul_ctl;
  ser_sts_t          mul_sts;
  logic [PROD_W-1:0] mul_prod;

  assign in_acc = in_bus.valid && in_rdy;

  // Restart takes the reset values in place of the held statistics
  always_comb begin
    if (in_bus.restart) begin
      cnt_base     = '0;
      total_base   = '0;
      mean_base    = '0;
      m2_base      = '0;
      max_base     = SAMPLE_MIN;
      max_idx_base = '1;
      min_base     = SAMPLE_MAX;
      min_idx_base = '1;
    end else begin
      cnt_base     = count_r;
      total_base   = total_r;
      mean_base    = mean_r;
      m2_base      = m2_r;
      max_base     = max_r;
      max_idx_base = max_idx_r;
      min_base     = min_r;
      min_idx_base = min_idx_r;
    end
  end

  // Count, saturating total, scaled sample, deviation and extremes on accept
  always_comb begin
    count_nxt  = (cnt_base == '1) ? cnt_base : cnt_base + COUNT_W'(1);
    pos_nxt    = POS_W'(count_nxt - COUNT_W'(1));
    sample_ext = TOTAL_W'(in_bus.sample);
    total_sum  = total_base + sample_ext;
    if ((total_base[TOTAL_W-1] == sample_ext[TOTAL_W-1]) &&
        (total_sum[TOTAL_W-1] != total_base[TOTAL_W-1])) begin
      total_nxt = total_base[TOTAL_W-1] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_nxt = total_sum;
    end
    xf_nxt    = {in_bus.sample, {FRAC_W{1'b0}}};
    delta_nxt = {xf_nxt[MEAN_W-1], xf_nxt} - {mean_base[MEAN_W-1], mean_base};
    take_max  = (max_idx_base == '1) || (in_bus.sample > max_base);
    take_min  = (min_idx_base == '1) || (in_bus.sample < min_base);
  end

  // Mean step, m2 increment with saturation, variance saturation
  always_comb begin
    if (delta_r[DELTA_W-1]) begin
      mean_upd = mean_r - div_quo[MAG_W-1:0];
    end else begin
      mean_upd = mean_r + div_quo[MAG_W-1:0];
    end
    dev_new = {xf_r[MEAN_W-1], xf_r} - {mean_r[MEAN_W-1], mean_r};
    if (mul_prod[PROD_W-1:M2_W+FRAC_W] != '0) begin
      m2_inc = '1;
    end else begin
      m2_inc = mul_prod[M2_W+FRAC_W-1:FRAC_W];
    end
    m2_sum  = {1'b0, m2_r} + {1'b0, m2_inc};
    m2_upd  = m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
    var_upd = div_quo[DIVIDEND_W-1] ? '1 : div_quo[VAR_W-1:0];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and unit requests
  always_comb begin
    state_nxt    = state_r;
    in_rdy       = 1'b0;
    out_load     = 1'b0;
    div_ctl      = '0;
    mul_ctl      = '0;
    div_dividend = {mag_of(delta_r), {DIV_PAD_W{1'b0}}};
    div_divisor  = count_r;
    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_bus.valid) begin
          state_nxt = ST_MEAN_GO;
        end
      end
      ST_MEAN_GO: begin
        div_ctl.start = 1'b1;
        div_ctl.last  = MEAN_DIV_LAST;
        state_nxt     = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_sts.done) begin
          state_nxt = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.last  = MUL_LAST;
        state_nxt     = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_sts.done) begin
          state_nxt = ST_VAR_GO;
        end
      end
      ST_VAR_GO: begin
        if (count_r < COUNT_W'(2)) begin
          state_nxt = ST_DONE;
        end else begin
          div_ctl.start = 1'b1;
          div_ctl.last  = VAR_DIV_LAST;
          div_dividend  = m2_r;
          div_divisor   = count_r - COUNT_W'(1);
          state_nxt     = ST_VAR_WAIT;
        end
      end
      ST_VAR_WAIT: begin
        if (div_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Statistics and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      mean_r      <= '0;
      m2_r        <= '0;
      max_r       <= SAMPLE_MIN;
      max_idx_r   <= '1;
      min_r       <= SAMPLE_MAX;
      min_idx_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        count_r   <= count_nxt;
        total_r   <= total_nxt;
        mean_r    <= mean_base;
        m2_r      <= m2_base;
        max_r     <= take_max ? in_bus.sample : max_base;
        max_idx_r <= take_max ? pos_nxt : max_idx_base;
        min_r     <= take_min ? in_bus.sample : min_base;
        min_idx_r <= take_min ? pos_nxt : min_idx_base;
      end
      if (state_r == ST_MEAN_WAIT && div_sts.done) begin
        mean_r <= mean_upd;
      end
      if (state_r == ST_MUL_WAIT && mul_sts.done) begin
        m2_r <= m2_upd;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working values and the output beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xf_r    <= xf_nxt;
      delta_r <= delta_nxt;
    end
    if (state_r == ST_VAR_GO && count_r < COUNT_W'(2)) begin
      var_r <= '0;
    end else if (state_r == ST_VAR_WAIT && div_sts.done) begin
      var_r <= var_upd;
    end
    if (out_load) begin
      out_r.sample_count    <= count_r;
      out_r.running_total   <= total_r;
      out_r.running_mean    <= mean_r;
      out_r.sample_variance <= var_r;
      out_r.max_value       <= max_r;
      out_r.max_position    <= max_idx_r;
      out_r.min_value       <= min_r;
      out_r.min_position    <= min_idx_r;
    end
  end

  rmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  rmv_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mul_ctl),
    .mcand   (mag_of(delta_r)),
    .mplier  (mag_of(dev_new)),
    .sts     (mul_sts),
    .product (mul_prod)
  );

  assign in_bus.ready            = in_rdy;
  assign out_bus.valid           = out_valid_r;
  assign out_bus.sample_count    = out_r.sample_count;
  assign out_bus.running_total   = out_r.running_total;
  assign out_bus.running_mean    = out_r.running_mean;
  assign out_bus.sample_variance = out_r.sample_variance;
  assign out_bus.max_value       = out_r.max_value;
  assign out_bus.max_position    = out_r.max_position;
  assign out_bus.min_value       = out_r.min_value;
  assign out_bus.min_position    = out_r.min_position;

  // A restart beat leaves exactly one sample counted
  a_restart_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_bus.restart |=> count_r == COUNT_W'(1))
    else $error("restart did not leave a count of one");

  // Divider results arrive only where the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == ST_MEAN_WAIT || state_r == ST_VAR_WAIT)
    else $error("divider done outside a divide wait");

  // Multiplier results arrive only where the sequencer waits for them
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> state_r == ST_MUL_WAIT)
    else $error("multiplier done outside the multiply wait");

  // Every taken sample leaves both extremes recorded
  a_extremes_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> max_idx_r != '1 && min_idx_r != '1)
    else $error("extreme position still empty after a sample");

endmodule
`default_nettype wire
